[rtl/deq_pkg.sv]
// Shared types and constants for the double-ended queue.
package deq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [CNT_W-1:0]         count_t;
    typedef logic [IDX_W-1:0]         idx_t;

    typedef enum logic [2:0] {
        MODE_PUSH_BACK  = 3'd0,
        MODE_PUSH_FRONT = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_LIST       = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_RIGHT,
        CELL_SHIFT_LEFT,
        CELL_PUSH_BACK,
        CELL_POP_BACK,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        data_t    push_data;
        data_t    head_data;
    } cell_ctl_t;

    typedef enum logic {
        ST_IDLE,
        ST_LIST
    } state_t;

endpackage

[rtl/double_ended_queue.sv]
// Top level of the bounded double-ended queue built as a chain of cells.
// A push, pop or empty-list result is registered and shows in the cycle after its transaction.
// Push and pop take a new transaction once their result is taken; a list holds the input until its last result loads.
// A list enters its state, then streams N results, one per cycle, by
// rotating the chain; a stalled result holds everything. Undefined modes yield nothing.
// Reset (synchronous, aresetn low) empties the chain and drops any pending result.
module double_ended_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_mode,
    input  deq_pkg::data_t       s_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output deq_pkg::data_t       m_value_out,
    output logic                 m_last,
    output deq_pkg::count_t      m_occupancy
);
    import deq_pkg::*;

    // Chain storage, cell 0 is the front of the deque.
    data_t     cell_data  [DEPTH];
    logic      cell_valid [DEPTH];
    data_t     cell_tail  [DEPTH];
    cell_ctl_t ctl;
    cell_op_t  op;
    data_t     tail_value;

    // Control and output registers.
    state_t  state_reg, state_next;
    count_t  count_reg, count_next;
    idx_t    list_idx_reg, list_idx_next;
    logic    m_valid_reg, m_valid_next;
    status_t m_status_reg, m_status_next;
    data_t   m_value_reg, m_value_next;
    logic    m_last_reg, m_last_next;
    count_t  m_occ_reg, m_occ_next;

    logic out_free;
    logic accept;
    logic load;
    logic list_last;

    // Build the chain: each cell sees its neighbors; the front sees the input value, the back a fixed empty boundary.
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            data_t l_data, r_data;
            logic  l_valid, r_valid;
            if (g == 0) begin : g_front
                assign l_data  = s_value;
                assign l_valid = 1'b1;
            end else begin : g_mid_l
                assign l_data  = cell_data[g-1];
                assign l_valid = cell_valid[g-1];
            end
            if (g == DEPTH - 1) begin : g_back
                assign r_data  = '0;
                assign r_valid = 1'b0;
            end else begin : g_mid_r
                assign r_data  = cell_data[g+1];
                assign r_valid = cell_valid[g+1];
            end
            deq_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctl         (ctl),
                .left_data   (l_data),
                .left_valid  (l_valid),
                .right_data  (r_data),
                .right_valid (r_valid),
                .data        (cell_data[g]),
                .valid       (cell_valid[g]),
                .tail_data   (cell_tail[g])
            );
        end
    endgenerate

    // Only the tail cell drives a non-zero tail value; merge them.
    always_comb begin
        tail_value = '0;
        for (int i = 0; i < DEPTH; i++) begin
            tail_value = tail_value | cell_tail[i];
        end
    end

    assign ctl.op        = op;
    assign ctl.push_data = s_value;
    assign ctl.head_data = cell_data[0];

    // The output register is free when empty or being drained this cycle.
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_valid && s_ready;
    assign list_last = (CNT_W'(list_idx_reg) == count_reg - CNT_W'(1));

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        list_idx_next = list_idx_reg;
        op            = CELL_HOLD;
        load          = 1'b0;
        m_status_next = m_status_reg;
        m_value_next  = m_value_reg;
        m_last_next   = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_mode)
                        MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
                            load         = 1'b1;
                            m_value_next = '0;
                            m_last_next  = 1'b1;
                            if (count_reg == CNT_W'(DEPTH)) begin
                                // drop the value, state unchanged
                                m_status_next = STATUS_FULL;
                            end else begin
                                m_status_next = STATUS_DONE;
                                count_next    = count_reg + CNT_W'(1);
                                op = (s_mode == MODE_PUSH_BACK) ? CELL_PUSH_BACK
                                                                : CELL_SHIFT_RIGHT;
                            end
                        end
                        MODE_POP_FRONT, MODE_POP_BACK: begin
                            load        = 1'b1;
                            m_last_next = 1'b1;
                            if (count_reg == '0) begin
                                m_status_next = STATUS_EMPTY;
                                m_value_next  = '0;
                            end else begin
                                m_status_next = STATUS_DONE;
                                count_next    = count_reg - CNT_W'(1);
                                if (s_mode == MODE_POP_FRONT) begin
                                    m_value_next = cell_data[0];
                                    op           = CELL_SHIFT_LEFT;
                                end else begin
                                    m_value_next = tail_value;
                                    op           = CELL_POP_BACK;
                                end
                            end
                        end
                        MODE_LIST: begin
                            if (count_reg == '0) begin
                                load          = 1'b1;
                                m_status_next = STATUS_EMPTY;
                                m_value_next  = '0;
                                m_last_next   = 1'b1;
                            end else begin
                                state_next    = ST_LIST;
                                list_idx_next = '0;
                            end
                        end
                        default: begin
                            // undefined mode: consume and drop
                        end
                    endcase
                end
            end
            ST_LIST: begin
                // Stream the front cell and rotate; after count steps the chain is restored.
                if (out_free) begin
                    load          = 1'b1;
                    op            = CELL_ROTATE;
                    m_status_next = STATUS_DONE;
                    m_value_next  = cell_data[0];
                    m_last_next   = list_last;
                    list_idx_next = list_idx_reg + IDX_W'(1);
                    if (list_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_occ_next = load ? count_next : m_occ_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            list_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            list_idx_reg <= list_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Hold the result payload until it is taken.
    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_value_reg  <= m_value_next;
        m_last_reg   <= m_last_next;
        m_occ_reg    <= m_occ_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_value_out = m_value_reg;
    assign m_last      = m_last_reg;
    assign m_occupancy = m_occ_reg;

endmodule

[rtl/deq_cell.sv]
// One storage cell of the deque chain: an element and its valid flag.
module deq_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  deq_pkg::cell_ctl_t ctl,
    input  deq_pkg::data_t    left_data,
    input  logic              left_valid,
    input  deq_pkg::data_t    right_data,
    input  logic              right_valid,
    output deq_pkg::data_t    data,
    output logic              valid,
    output deq_pkg::data_t    tail_data
);
    import deq_pkg::*;

    data_t data_reg, data_next;
    logic  valid_reg, valid_next;
    logic  is_tail;
    logic  is_first_free;

    assign is_tail       = valid_reg & ~right_valid;
    assign is_first_free = ~valid_reg & left_valid;

    always_comb begin
        data_next  = data_reg;
        valid_next = valid_reg;
        case (ctl.op)
            CELL_HOLD: begin
            end
            CELL_SHIFT_RIGHT: begin
                data_next  = left_data;
                valid_next = left_valid;
            end
            CELL_SHIFT_LEFT: begin
                data_next  = right_data;
                valid_next = right_valid;
            end
            CELL_PUSH_BACK: begin
                if (is_first_free) begin
                    data_next  = ctl.push_data;
                    valid_next = 1'b1;
                end
            end
            CELL_POP_BACK: begin
                if (is_tail) begin
                    valid_next = 1'b0;
                end
            end
            CELL_ROTATE: begin
                // the tail wraps the head element around
                if (valid_reg) begin
                    data_next = is_tail ? ctl.head_data : right_data;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data      = data_reg;
    assign valid     = valid_reg;
    assign tail_data = is_tail ? data_reg : '0;

endmodule

[rtl/deq_checker.sv]
// Port-level checker for the double-ended queue, bound to the top level.
module deq_assertions (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_ready,
    input logic            m_valid,
    input logic            m_ready,
    input logic [1:0]      m_status,
    input deq_pkg::data_t  m_value_out,
    input logic            m_last,
    input deq_pkg::count_t m_occupancy
);
    import deq_pkg::*;

    // A pending result transaction holds until taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value_out) && $stable(m_status))
        else $error("result changed while stalled");

    // A stalled result blocks new input.
    a_in_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while result stalled");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_FULL |->
            m_occupancy == CNT_W'(DEPTH) && m_value_out == '0 && m_last)
        else $error("full report inconsistent");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_EMPTY |->
            m_occupancy == '0 && m_value_out == '0 && m_last)
        else $error("empty report inconsistent");

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_occupancy <= CNT_W'(DEPTH) && m_status != 2'd3)
        else $error("occupancy or status out of range");

endmodule

bind double_ended_queue deq_assertions u_deq_assertions (.*);
